// File: hw/rtl/a85_pkg.sv
// Shared types, constants and the CRC helper of the ASCII85 line encoder.
// No dependencies; every other file of the encoder refers to this package.
package a85_pkg;

	// Group queue depth between the byte packer and the character back end
	localparam int unsigned QUEUE_DEPTH = 2;

	// Configuration port
	localparam int unsigned ADDR_W = 3;
	localparam logic [0:0] REG_LINE_CHARS = 1'b0;
	localparam logic [7:0] LINE_CHARS_RESET = 8'd80;

	// Line check CRC-32, reflected form
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	// Base-85 digits: q = (v * RECIP_85) >> RECIP_SHIFT is exact for any 32-bit v
	localparam logic [6:0] B85_BIAS = 7'd33;
	localparam logic [31:0] RECIP_85 = 32'hC0C0C0C1;
	localparam int unsigned RECIP_SHIFT = 38;
	localparam int unsigned QUO_W = 26;

	// One zero-padded 32-bit group and its end-of-stream mark
	typedef struct packed {
		logic [31:0] value;
		logic last;
	} group_t;

	// Write side of the group queue
	typedef struct packed {
		logic valid;
		group_t item;
	} push_t;

	// Queue status seen by the packer and the back end
	typedef struct packed {
		logic full;
		logic avail;
	} qstat_t;

	// Advance the CRC register over one character
	function automatic logic [31:0] crc_char(input logic [31:0] crc, input logic [7:0] c);
		logic [31:0] r;
		r = crc ^ {24'd0, c};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/a85_front.sv
// Byte packer: accepts input bytes and assembles big-endian 32-bit groups.
// Uses a85_pkg (push_t, qstat_t); feeds a85_queue.
module a85_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [7:0] data_byte,
	input logic in_last,
	input a85_pkg::qstat_t qstat,
	output logic in_stall,
	output a85_pkg::push_t push
);

	logic [23:0] held_q;
	logic [1:0] fill_q;
	logic accept;
	logic [31:0] packed_val;

	// Hold off new bytes while the group queue has no room
	assign in_stall = qstat.full;
	assign accept = in_valid && !qstat.full;

	// Place the new byte after the held ones and pad with zero bytes
	always_comb begin
		case (fill_q)
			2'd0: packed_val = {data_byte, 24'd0};
			2'd1: packed_val = {held_q[7:0], data_byte, 16'd0};
			2'd2: packed_val = {held_q[15:0], data_byte, 8'd0};
			2'd3: packed_val = {held_q, data_byte};
			default: packed_val = {held_q, data_byte};
		endcase
	end

	// Send a group on the fourth byte or at end of stream
	assign push.valid = accept && (fill_q == 2'd3 || in_last);
	assign push.item.value = packed_val;
	assign push.item.last = in_last;

	// Count bytes held in the current group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else if (accept) begin
			if (push.valid) begin
				fill_q <= 2'd0;
			end else begin
				fill_q <= fill_q + 2'd1;
			end
		end
	end

	// Shift accepted bytes into the holding register
	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= {held_q[15:0], data_byte};
		end
	end

endmodule

// File: hw/rtl/a85_queue.sv
// Short group queue between the byte packer and the character back end.
// Uses a85_pkg (group_t, push_t, qstat_t).
module a85_queue #(
	parameter int unsigned DEPTH = a85_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input a85_pkg::push_t push,
	input logic pop,
	output a85_pkg::qstat_t qstat,
	output a85_pkg::group_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	a85_pkg::group_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign qstat.full = (count_q == FULL_CNT);
	assign qstat.avail = (count_q != '0);
	assign head = slot_q[rd_q];

	// Store pushed groups
	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_q] <= push.item;
		end
	end

	// Advance pointers and track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			case ({push.valid, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/a85_back.sv
// Back end: splits each group into five base-85 digits, then sends them as
// characters with line cutting and the per-line CRC. Uses a85_pkg.
module a85_back (
	input logic clk,
	input logic arst_n,
	input logic [7:0] line_chars,
	input a85_pkg::qstat_t qstat,
	input a85_pkg::group_t head,
	output logic pop,
	output logic out_valid,
	output logic [6:0] out_char,
	output logic line_end,
	output logic [15:0] line_check,
	output logic out_last,
	input logic out_stall
);

	// Digit converter
	logic conv_busy_q;
	logic conv_rdy_q;
	logic conv_last_q;
	logic [1:0] conv_cnt_q;
	logic [31:0] conv_val_q;
	logic [6:0] rem_q [4];
	logic [63:0] prod;
	logic [a85_pkg::QUO_W-1:0] quo;
	logic [31:0] quo85;
	logic [31:0] diff;

	// Character emitter
	logic em_busy_q;
	logic em_last_q;
	logic [2:0] em_cnt_q;
	logic [6:0] em_dig_q [5];
	logic [31:0] crc_q;
	logic [7:0] lc_q;

	// Output register
	logic out_valid_q;
	logic [6:0] out_char_q;
	logic line_end_q;
	logic [15:0] line_check_q;
	logic out_last_q;

	logic out_free;
	logic emit;
	logic em_final;
	logic xfer;
	logic load;
	logic [6:0] char_c;
	logic [31:0] crc_n;
	logic [7:0] lc_n;
	logic end_c;

	// Handoff conditions between queue, converter, emitter and output register
	assign out_free = !out_valid_q || !out_stall;
	assign emit = em_busy_q && out_free;
	assign em_final = emit && (em_cnt_q == 3'd1);
	assign xfer = conv_rdy_q && (!em_busy_q || em_final);
	assign load = qstat.avail && !conv_busy_q && (!conv_rdy_q || xfer);
	assign pop = load;

	// Divide by 85 through the reciprocal, then take the remainder
	assign prod = {32'd0, conv_val_q} * {32'd0, a85_pkg::RECIP_85};
	assign quo = prod[a85_pkg::RECIP_SHIFT +: a85_pkg::QUO_W];
	assign quo85 = {quo, 6'd0} + {2'd0, quo, 4'd0} + {4'd0, quo, 2'd0} + {6'd0, quo};
	assign diff = conv_val_q - quo85;

	// Converter control: four division steps, then wait for the emitter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_busy_q <= 1'b0;
			conv_rdy_q <= 1'b0;
			conv_cnt_q <= 2'd0;
		end else begin
			if (xfer) begin
				conv_rdy_q <= 1'b0;
			end
			if (load) begin
				conv_busy_q <= 1'b1;
				conv_cnt_q <= 2'd0;
			end else if (conv_busy_q) begin
				conv_cnt_q <= conv_cnt_q + 2'd1;
				if (conv_cnt_q == 2'd3) begin
					conv_busy_q <= 1'b0;
					conv_rdy_q <= 1'b1;
				end
			end
		end
	end

	// Converter data: keep the quotient, shift remainders in low digit first
	always_ff @(posedge clk) begin
		if (load) begin
			conv_val_q <= head.value;
			conv_last_q <= head.last;
		end else if (conv_busy_q) begin
			conv_val_q <= {{(32 - a85_pkg::QUO_W){1'b0}}, quo};
			rem_q[0] <= diff[6:0];
			for (int i = 1; i < 4; i++) begin
				rem_q[i] <= rem_q[i-1];
			end
		end
	end

	// Emitter control: count down five characters per group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_busy_q <= 1'b0;
			em_cnt_q <= 3'd0;
		end else begin
			if (emit) begin
				em_cnt_q <= em_cnt_q - 3'd1;
				if (em_final) begin
					em_busy_q <= 1'b0;
				end
			end
			if (xfer) begin
				em_busy_q <= 1'b1;
				em_cnt_q <= 3'd5;
			end
		end
	end

	// Emitter data: load digits high first, shift one out per character
	always_ff @(posedge clk) begin
		if (xfer) begin
			em_dig_q[0] <= conv_val_q[6:0];
			em_dig_q[1] <= rem_q[0];
			em_dig_q[2] <= rem_q[1];
			em_dig_q[3] <= rem_q[2];
			em_dig_q[4] <= rem_q[3];
			em_last_q <= conv_last_q;
		end else if (emit) begin
			for (int i = 0; i < 4; i++) begin
				em_dig_q[i] <= em_dig_q[i+1];
			end
		end
	end

	// Next character, its CRC and line position
	assign char_c = em_dig_q[0] + a85_pkg::B85_BIAS;
	assign crc_n = a85_pkg::crc_char(crc_q, {1'b0, char_c});
	assign lc_n = lc_q + 8'd1;
	assign end_c = (lc_n == line_chars) || (em_last_q && em_cnt_q == 3'd1);

	// Line state: restart count and CRC after each line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= a85_pkg::CRC_INIT;
			lc_q <= 8'd0;
		end else if (emit) begin
			if (end_c) begin
				crc_q <= a85_pkg::CRC_INIT;
				lc_q <= 8'd0;
			end else begin
				crc_q <= crc_n;
				lc_q <= lc_n;
			end
		end
	end

	// Output valid: set on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= char_c;
			line_end_q <= end_c;
			line_check_q <= end_c ? ~crc_n[15:0] : 16'd0;
			out_last_q <= em_last_q && (em_cnt_q == 3'd1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign line_end = line_end_q;
	assign line_check = line_check_q;
	assign out_last = out_last_q;

endmodule

// File: hw/rtl/ascii85_line_encoder_with_crc.sv
// Top level of the ASCII85 line encoder: register port, packer, queue, back end.
// Uses a85_pkg, a85_front, a85_queue and a85_back.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall   data_byte, in_last
//   out      source     out_valid / out_stall out_char, line_end, line_check, out_last
//   cfg      APB slave  psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// Four bytes make one group, sent as five characters at one per cycle while
// out_stall is low, so the character output register sets the sustained rate.
// Each group passes through the divide-by-85 unit (one 32x32 multiply a cycle),
// overlapped with emission of the previous group.
// Reset clears all control state and sets line_chars to 80.
// in_stall rises while the group queue is full; out_stall holds output and emitter.
module ascii85_line_encoder_with_crc #(
	parameter int unsigned QUEUE_DEPTH = a85_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [a85_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] data_byte,
	input logic in_last,
	output logic out_valid,
	input logic out_stall,
	output logic [6:0] out_char,
	output logic line_end,
	output logic [15:0] line_check,
	output logic out_last
);

	logic [7:0] line_chars_q;
	logic reg_sel;
	a85_pkg::push_t push;
	a85_pkg::qstat_t qstat;
	a85_pkg::group_t head;
	logic pop;

	// Register port: single register, no wait states
	assign pready = 1'b1;
	assign reg_sel = (paddr[a85_pkg::ADDR_W-1:2] == a85_pkg::REG_LINE_CHARS);
	assign prdata = reg_sel ? {24'd0, line_chars_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_chars_q <= a85_pkg::LINE_CHARS_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			line_chars_q <= pwdata[7:0];
		end
	end

	a85_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.data_byte(data_byte),
		.in_last(in_last),
		.qstat(qstat),
		.in_stall(in_stall),
		.push(push)
	);

	a85_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(pop),
		.qstat(qstat),
		.head(head)
	);

	a85_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.line_chars(line_chars_q),
		.qstat(qstat),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_char(out_char),
		.line_end(line_end),
		.line_check(line_check),
		.out_last(out_last),
		.out_stall(out_stall)
	);

	// Never push a group into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) push.valid |-> !qstat.full)
		else $error("group pushed into full queue");

	// Never pop an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> qstat.avail)
		else $error("pop from empty queue");

	// Final character of the stream always closes its line
	assert property (@(posedge clk) disable iff (!arst_n) (out_valid && out_last) |-> line_end)
		else $error("stream end without line end");

	// Check field is zero away from a line end
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !line_end) |-> (line_check == 16'd0))
		else $error("line check set mid-line");

	// Characters stay in the base-85 range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char >= 7'd33 && out_char <= 7'd117))
		else $error("character out of range");

endmodule
